>>> hw/rtl/frame_difference_motion_detector_core_defines.svh
// Assertion macros shared by the checker files of the motion detector core.
`ifndef FRAME_DIFFERENCE_MOTION_DETECTOR_CORE_DEFINES_SVH
`define FRAME_DIFFERENCE_MOTION_DETECTOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FDMD_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FDMD_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/fdmd_pkg.sv
// Shared constants, codes and types of the frame difference motion detector.
`default_nettype none

package fdmd_pkg;

    localparam int WINDOW_SIZE_DEF = 240;
    localparam int QUEUE_DEPTH     = 4;

    localparam int LUMA_W     = 8;
    localparam int POS_W      = 11;
    localparam int THR_W      = 16;
    localparam int COUNT_W    = 16;
    localparam int SKIP_W     = 8;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Frame kinds reported with each result
    localparam logic [KIND_W-1:0] KIND_LOAD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SKIP    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPARE = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_ORIGIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_ORIGIN = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP       = 3'd5;

    // Configuration reset values
    localparam logic [POS_W-1:0]  RST_ROW_ORIGIN = 11'd120;
    localparam logic [POS_W-1:0]  RST_COL_ORIGIN = 11'd200;
    localparam logic [THR_W-1:0]  RST_DIFF_THR   = 16'd25;
    localparam logic [THR_W-1:0]  RST_HIGH_THR   = 16'd12000;
    localparam logic [THR_W-1:0]  RST_LOW_THR    = 16'd300;
    localparam logic [SKIP_W-1:0] RST_SKIP       = 8'd3;

    typedef struct packed {
        logic [POS_W-1:0]  row_origin;
        logic [POS_W-1:0]  col_origin;
        logic [THR_W-1:0]  diff_thr;
        logic [THR_W-1:0]  high_thr;
        logic [THR_W-1:0]  low_thr;
        logic [SKIP_W-1:0] skip_frames;
    } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/fdmd_front.sv
// Front end: takes pixel requests, crops the window and forms the reference address.
`default_nettype none

module fdmd_front #(
    parameter int WINDOW_SIZE = fdmd_pkg::WINDOW_SIZE_DEF,
    localparam int ROW_W  = $clog2(WINDOW_SIZE),
    localparam int ADDR_W = $clog2(WINDOW_SIZE * WINDOW_SIZE)
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire fdmd_pkg::cfg_t               cfg,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [fdmd_pkg::LUMA_W-1:0]  luma,
    input  wire logic [fdmd_pkg::POS_W-1:0]   row,
    input  wire logic [fdmd_pkg::POS_W-1:0]   col,
    input  wire logic                         frame_last,
    input  wire logic                         q_full,
    output logic                              q_push,
    output logic [fdmd_pkg::LUMA_W-1:0]       q_luma,
    output logic                              q_in_win,
    output logic                              q_last,
    output logic [ADDR_W-1:0]                 q_addr
);

    logic                        f_valid_reg;
    logic [fdmd_pkg::LUMA_W-1:0] f_luma_reg;
    logic [ROW_W-1:0]            f_r_reg;
    logic [ROW_W-1:0]            f_c_reg;
    logic                        f_in_win_reg;
    logic                        f_last_reg;

    logic                        accept;
    logic [fdmd_pkg::POS_W:0]    row_off;
    logic [fdmd_pkg::POS_W:0]    col_off;
    logic                        row_in;
    logic                        col_in;

    assign in_stall = f_valid_reg && q_full;
    assign q_push   = f_valid_reg && !q_full;
    assign accept   = in_valid && !in_stall;

    // Offset from the window origin; the top bit is the borrow
    assign row_off = {1'b0, row} - {1'b0, cfg.row_origin};
    assign col_off = {1'b0, col} - {1'b0, cfg.col_origin};
    assign row_in  = !row_off[fdmd_pkg::POS_W] &&
                     (row_off[fdmd_pkg::POS_W-1:0] < fdmd_pkg::POS_W'(WINDOW_SIZE));
    assign col_in  = !col_off[fdmd_pkg::POS_W] &&
                     (col_off[fdmd_pkg::POS_W-1:0] < fdmd_pkg::POS_W'(WINDOW_SIZE));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            f_valid_reg <= 1'b1;
        end
        else if (q_push)
        begin
            f_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f_luma_reg   <= luma;
            f_r_reg      <= row_off[ROW_W-1:0];
            f_c_reg      <= col_off[ROW_W-1:0];
            f_in_win_reg <= row_in && col_in;
            f_last_reg   <= frame_last;
        end
    end

    assign q_luma   = f_luma_reg;
    assign q_in_win = f_in_win_reg;
    assign q_last   = f_last_reg;
    assign q_addr   = ADDR_W'(f_r_reg) * ADDR_W'(WINDOW_SIZE) + ADDR_W'(f_c_reg);

endmodule

`default_nettype wire

>>> hw/rtl/fdmd_queue.sv
// Short FIFO between the front end and the back end.
`default_nettype none

module fdmd_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = fdmd_pkg::QUEUE_DEPTH,
    localparam int PTR_W = $clog2(DEPTH),
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire logic [DATA_W-1:0] wr_data,
    output logic                   full,
    input  wire logic              pop,
    output logic                   not_empty,
    output logic [DATA_W-1:0]      rd_data
);

    logic [DATA_W-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_data   = entry_reg[rd_ptr_reg];

    assign wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
    assign rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_next;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_next;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/fdmd_back.sv
// Back end: reference read-modify-write, change count and per-frame decision.
`default_nettype none

module fdmd_back #(
    parameter int WINDOW_SIZE = fdmd_pkg::WINDOW_SIZE_DEF,
    localparam int AREA      = WINDOW_SIZE * WINDOW_SIZE,
    localparam int ADDR_W    = $clog2(AREA),
    localparam int COUNT_CAP = (AREA < 65535) ? AREA : 65535
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire fdmd_pkg::cfg_t                cfg,
    input  wire logic                          q_valid,
    input  wire logic [fdmd_pkg::LUMA_W-1:0]   q_luma,
    input  wire logic                          q_in_win,
    input  wire logic                          q_last,
    input  wire logic [ADDR_W-1:0]             q_addr,
    output logic                               q_pop,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [fdmd_pkg::KIND_W-1:0]        frame_kind,
    output logic [fdmd_pkg::COUNT_W-1:0]       changed_count,
    output logic                               moving,
    output logic                               move_done
);

    logic [fdmd_pkg::LUMA_W-1:0] ref_mem [AREA];

    // Stage 1: classified pixel, reference read in flight
    logic                         s1_valid_reg;
    logic                         s1_in_win_reg;
    logic                         s1_last_reg;
    logic [fdmd_pkg::KIND_W-1:0]  s1_kind_reg;
    logic [fdmd_pkg::LUMA_W-1:0]  s1_luma_reg;
    logic [ADDR_W-1:0]            s1_addr_reg;
    logic [fdmd_pkg::LUMA_W-1:0]  rd_data_reg;
    logic [fdmd_pkg::LUMA_W-1:0]  fwd_data_reg;
    logic                         fwd_hit_reg;

    // Stage 2: change flag, accumulate and close the frame
    logic                         s2_valid_reg;
    logic                         s2_changed_reg;
    logic                         s2_last_reg;
    logic [fdmd_pkg::KIND_W-1:0]  s2_kind_reg;

    logic [fdmd_pkg::COUNT_W-1:0] acc_reg;
    logic                         flag_reg;
    logic                         need_ref_reg;
    logic [fdmd_pkg::SKIP_W-1:0]  skip_cnt_reg;

    logic                         out_valid_reg;
    logic [fdmd_pkg::KIND_W-1:0]  out_kind_reg;
    logic [fdmd_pkg::COUNT_W-1:0] out_count_reg;
    logic                         out_moving_reg;
    logic                         out_done_reg;

    logic                         adv;
    logic                         frame_end;
    logic [fdmd_pkg::KIND_W-1:0]  kind_next;
    logic                         s1_wr;
    logic [fdmd_pkg::LUMA_W-1:0]  old_luma;
    logic [fdmd_pkg::LUMA_W-1:0]  diff;
    logic [15:0]                  diff_sq;
    logic                         changed_next;
    logic [fdmd_pkg::COUNT_W-1:0] acc_sum;
    logic [fdmd_pkg::COUNT_W-1:0] acc_next;
    logic [fdmd_pkg::COUNT_W-1:0] count_next;
    logic                         flag_next;
    logic                         need_ref_next;
    logic                         done_next;
    logic [fdmd_pkg::SKIP_W-1:0]  skip_cnt_next;

    // Freeze the whole pipe only when a frame result cannot leave
    assign frame_end = s2_valid_reg && s2_last_reg;
    assign adv       = !(frame_end && out_valid_reg && out_stall);

    // Hold new pixels while a frame end is in flight: its decision sets the next kind
    assign q_pop = adv && q_valid && !(s1_valid_reg && s1_last_reg) && !frame_end;

    assign kind_next = need_ref_reg ? fdmd_pkg::KIND_LOAD :
                       (skip_cnt_reg == cfg.skip_frames) ? fdmd_pkg::KIND_COMPARE :
                       fdmd_pkg::KIND_SKIP;

    assign s1_wr = s1_valid_reg && s1_in_win_reg && (s1_kind_reg != fdmd_pkg::KIND_SKIP);

    assign old_luma = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
    assign diff     = (old_luma > s1_luma_reg) ? old_luma - s1_luma_reg
                                               : s1_luma_reg - old_luma;
    assign diff_sq  = 16'(diff) * 16'(diff);
    assign changed_next = s1_valid_reg && s1_in_win_reg &&
                          (s1_kind_reg == fdmd_pkg::KIND_COMPARE) &&
                          (diff_sq > cfg.diff_thr);

    assign acc_sum = (s2_changed_reg && (acc_reg < fdmd_pkg::COUNT_W'(COUNT_CAP)))
                     ? acc_reg + fdmd_pkg::COUNT_W'(1) : acc_reg;

    always_comb
    begin
        acc_next      = acc_reg;
        count_next    = '0;
        flag_next     = flag_reg;
        need_ref_next = need_ref_reg;
        done_next     = 1'b0;
        skip_cnt_next = skip_cnt_reg;
        if (s2_valid_reg)
        begin
            acc_next = acc_sum;
        end
        if (frame_end)
        begin
            acc_next = '0;
            case (s2_kind_reg)
                fdmd_pkg::KIND_LOAD:
                begin
                    need_ref_next = 1'b0;
                    skip_cnt_next = '0;
                end
                fdmd_pkg::KIND_SKIP:
                begin
                    skip_cnt_next = skip_cnt_reg + fdmd_pkg::SKIP_W'(1);
                end
                fdmd_pkg::KIND_COMPARE:
                begin
                    count_next    = acc_sum;
                    skip_cnt_next = '0;
                    if ((acc_sum > cfg.high_thr) && !flag_reg)
                    begin
                        flag_next = 1'b1;
                    end
                    else if ((acc_sum < cfg.low_thr) && flag_reg)
                    begin
                        flag_next     = 1'b0;
                        done_next     = 1'b1;
                        need_ref_next = 1'b1;
                    end
                end
                default:
                begin
                    acc_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            acc_reg       <= '0;
            flag_reg      <= 1'b0;
            need_ref_reg  <= 1'b1;
            skip_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg <= q_pop;
                s2_valid_reg <= s1_valid_reg;
                acc_reg      <= acc_next;
                flag_reg     <= flag_next;
                need_ref_reg <= need_ref_next;
                skip_cnt_reg <= skip_cnt_next;
            end
            if (q_pop)
            begin
                fwd_hit_reg <= s1_wr && (s1_addr_reg == q_addr);
            end
            if (adv && frame_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Reference store: write the stage 1 pixel, read the next one
    always_ff @(posedge clk)
    begin
        if (adv && s1_wr)
        begin
            ref_mem[s1_addr_reg] <= s1_luma_reg;
        end
        if (q_pop)
        begin
            rd_data_reg  <= ref_mem[q_addr];
            fwd_data_reg <= s1_luma_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            s1_in_win_reg <= q_in_win;
            s1_last_reg   <= q_last;
            s1_kind_reg   <= kind_next;
            s1_luma_reg   <= q_luma;
            s1_addr_reg   <= q_addr;
        end
        if (adv)
        begin
            s2_changed_reg <= changed_next;
            s2_last_reg    <= s1_last_reg;
            s2_kind_reg    <= s1_kind_reg;
        end
        if (adv && frame_end)
        begin
            out_kind_reg   <= s2_kind_reg;
            out_count_reg  <= count_next;
            out_moving_reg <= flag_next;
            out_done_reg   <= done_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_kind    = out_kind_reg;
    assign changed_count = out_count_reg;
    assign moving        = out_moving_reg;
    assign move_done     = out_done_reg;

endmodule

`default_nettype wire

>>> hw/rtl/frame_difference_motion_detector_core.sv
// Top level of the frame difference motion detector: config registers and wiring.
//
// Pixel requests (luma, row, col, frame_last) enter on in_valid/in_stall; one
// result request per frame leaves on out_valid/out_stall at the frame's last
// pixel. Each channel moves a request at a clock edge with valid high and stall
// low. Configuration is written through cfg_we/cfg_index/cfg_data, one register
// per edge; the user must write it only while the block is idle, which the block
// does not enforce. Indexes past the register list are dropped. Throughput: one
// pixel per cycle while no stall holds the flow; at each frame end the back end
// holds the next frame's first pixel until the frame decision (reference load,
// skip or compare) has been made. A four-entry queue absorbs that hold-off.
// Path: front register, queue, reference read stage, count stage, output register.
// The reference store is a WINDOW_SIZE x WINDOW_SIZE byte memory read and
// written once per cycle; back-to-back hits on one address are forwarded.
// Reset clears the counters and flags, arms a reference load and restores the
// register defaults; the reference store itself is not cleared.
// A stalled result is held in the output register; the pipe keeps taking pixels
// until the next frame end reaches it, then the queue fills and in_stall rises.
`default_nettype none

module frame_difference_motion_detector_core #(
    parameter int WINDOW_SIZE = fdmd_pkg::WINDOW_SIZE_DEF,
    parameter int QUEUE_DEPTH = fdmd_pkg::QUEUE_DEPTH
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [fdmd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [fdmd_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [fdmd_pkg::LUMA_W-1:0]       luma,
    input  wire logic [fdmd_pkg::POS_W-1:0]        row,
    input  wire logic [fdmd_pkg::POS_W-1:0]        col,
    input  wire logic                              frame_last,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [fdmd_pkg::KIND_W-1:0]            frame_kind,
    output logic [fdmd_pkg::COUNT_W-1:0]           changed_count,
    output logic                                   moving,
    output logic                                   move_done
);

    localparam int ADDR_W = $clog2(WINDOW_SIZE * WINDOW_SIZE);
    localparam int Q_W    = fdmd_pkg::LUMA_W + 2 + ADDR_W;

    fdmd_pkg::cfg_t cfg_reg;

    logic                        f_push;
    logic [fdmd_pkg::LUMA_W-1:0] f_luma;
    logic                        f_in_win;
    logic                        f_last;
    logic [ADDR_W-1:0]           f_addr;
    logic                        q_full;
    logic                        q_not_empty;
    logic                        q_pop;
    logic [Q_W-1:0]              q_wr_data;
    logic [Q_W-1:0]              q_rd_data;

    // Register writes; unknown indexes fall through
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_origin  <= fdmd_pkg::RST_ROW_ORIGIN;
            cfg_reg.col_origin  <= fdmd_pkg::RST_COL_ORIGIN;
            cfg_reg.diff_thr    <= fdmd_pkg::RST_DIFF_THR;
            cfg_reg.high_thr    <= fdmd_pkg::RST_HIGH_THR;
            cfg_reg.low_thr     <= fdmd_pkg::RST_LOW_THR;
            cfg_reg.skip_frames <= fdmd_pkg::RST_SKIP;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                fdmd_pkg::CFG_ROW_ORIGIN: cfg_reg.row_origin  <= cfg_data[fdmd_pkg::POS_W-1:0];
                fdmd_pkg::CFG_COL_ORIGIN: cfg_reg.col_origin  <= cfg_data[fdmd_pkg::POS_W-1:0];
                fdmd_pkg::CFG_DIFF_THR:   cfg_reg.diff_thr    <= cfg_data;
                fdmd_pkg::CFG_HIGH_THR:   cfg_reg.high_thr    <= cfg_data;
                fdmd_pkg::CFG_LOW_THR:    cfg_reg.low_thr     <= cfg_data;
                fdmd_pkg::CFG_SKIP:       cfg_reg.skip_frames <= cfg_data[fdmd_pkg::SKIP_W-1:0];
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // Crop and address the incoming pixel
    fdmd_front #(
        .WINDOW_SIZE(WINDOW_SIZE)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .luma       (luma),
        .row        (row),
        .col        (col),
        .frame_last (frame_last),
        .q_full     (q_full),
        .q_push     (f_push),
        .q_luma     (f_luma),
        .q_in_win   (f_in_win),
        .q_last     (f_last),
        .q_addr     (f_addr)
    );

    assign q_wr_data = {f_luma, f_in_win, f_last, f_addr};

    // Decouple the front end from the back end stalls
    fdmd_queue #(
        .DATA_W (Q_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (f_push),
        .wr_data   (q_wr_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rd_data   (q_rd_data)
    );

    // Compare against the reference, count and decide per frame
    fdmd_back #(
        .WINDOW_SIZE(WINDOW_SIZE)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_not_empty),
        .q_luma        (q_rd_data[Q_W-1 -: fdmd_pkg::LUMA_W]),
        .q_in_win      (q_rd_data[ADDR_W+1]),
        .q_last        (q_rd_data[ADDR_W]),
        .q_addr        (q_rd_data[ADDR_W-1:0]),
        .q_pop         (q_pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_kind    (frame_kind),
        .changed_count (changed_count),
        .moving        (moving),
        .move_done     (move_done)
    );

endmodule

`default_nettype wire

>>> hw/rtl/fdmd_checker.sv
// Port-level checks on the motion detector result channel, bound to the top level.
`default_nettype none
`include "frame_difference_motion_detector_core_defines.svh"

module fdmd_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        out_valid,
    input  wire logic                        out_stall,
    input  wire logic [fdmd_pkg::KIND_W-1:0] frame_kind,
    input  wire logic [fdmd_pkg::COUNT_W-1:0] changed_count,
    input  wire logic                        moving,
    input  wire logic                        move_done
);

    // A stalled result holds
    `FDMD_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(frame_kind) && $stable(changed_count) && $stable(moving) && $stable(move_done), "stalled result changed")

    // Only compared frames carry a count or end an episode
    `FDMD_ASSERT_IMP(a_count_compare_only, clk, rst_n, out_valid && (frame_kind != fdmd_pkg::KIND_COMPARE), (changed_count == '0) && !move_done, "count or done on a frame that was not compared")

    // Ending an episode clears the flag
    `FDMD_ASSERT_IMP(a_done_clears, clk, rst_n, out_valid && move_done, !moving, "move done with flag still set")

    // A reference load only follows reset or a finished episode
    `FDMD_ASSERT_IMP(a_load_idle, clk, rst_n, out_valid && (frame_kind == fdmd_pkg::KIND_LOAD), !moving, "reference loaded while moving")

endmodule

bind frame_difference_motion_detector_core fdmd_checker u_fdmd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_kind    (frame_kind),
    .changed_count (changed_count),
    .moving        (moving),
    .move_done     (move_done)
);

`default_nettype wire

>>> tb/sv/frame_difference_motion_detector_core_test.sv
// Self-checking testbench of the frame difference motion detector core.
`timescale 1ns / 100ps

module frame_difference_motion_detector_core_test;

    import fdmd_pkg::*;

    // Geometry of the crop window and the ceiling of the changed-pixel count
    localparam int WINDOW    = WINDOW_SIZE_DEF;
    localparam int AREA      = WINDOW * WINDOW;
    localparam int COUNT_CAP = (AREA < 65535) ? AREA : 65535;
    localparam int POS_MAX   = (1 << POS_W) - 1;

    // Run control
    localparam int SETTLE_CYCLES  = 8;     // lets the result pipe drain
    localparam int LONG_HOLD      = 400;   // one long output hold-off
    localparam int STALL_LIMIT    = 3000;  // cycles with no handshake at all
    localparam int MAX_REPORTS    = 10;
    localparam int EDGE_POINTS    = 18;    // window rows/cols used per axis

    // Index past the register list; the core drops writes to it
    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 3'd7;

    typedef struct packed {
        logic [LUMA_W-1:0] luma;
        logic [POS_W-1:0]  row;
        logic [POS_W-1:0]  col;
        logic              last;
    } pixel_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COUNT_W-1:0] count;
        logic               flag;
        logic               done;
    } frame_report_t;

    // Ports of the core
    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    logic                  in_stall;
    logic [LUMA_W-1:0]     luma       = '0;
    logic [POS_W-1:0]      row        = '0;
    logic [POS_W-1:0]      col        = '0;
    logic                  frame_last = 1'b0;
    logic                  out_valid;
    logic                  out_stall  = 1'b0;
    logic [KIND_W-1:0]     frame_kind;
    logic [COUNT_W-1:0]    changed_count;
    logic                  moving;
    logic                  move_done;

    // Pixel requests waiting for the driver, and frame results still owed
    pixel_t        pixel_backlog[$];
    frame_report_t expected_frames[$];

    // Idling knobs, percent per cycle; set by the stimulus between phases
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    bit long_hold_req  = 1'b0;
    int hold_left      = 0;

    int mismatch_count = 0;
    int idle_cycles    = 0;

    // Detector state as this bench tracks it, with its own copy of the registers
    logic [LUMA_W-1:0]  background_luma [0:AREA-1];
    logic [COUNT_W-1:0] change_tally   = '0;
    logic               motion_on      = 1'b0;
    logic               reload_pending = 1'b1;
    logic [SKIP_W-1:0]  skips_seen     = '0;
    cfg_t det_cfg = '{row_origin: RST_ROW_ORIGIN, col_origin: RST_COL_ORIGIN,
                      diff_thr: RST_DIFF_THR, high_thr: RST_HIGH_THR,
                      low_thr: RST_LOW_THR, skip_frames: RST_SKIP};

    frame_difference_motion_detector_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .luma          (luma),
        .row           (row),
        .col           (col),
        .frame_last    (frame_last),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .frame_kind    (frame_kind),
        .changed_count (changed_count),
        .moving        (moving),
        .move_done     (move_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Mirror a register write; keep only the bits the register holds.
    task automatic apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_ROW_ORIGIN)
            det_cfg.row_origin = data[POS_W-1:0];
        else if (idx == CFG_COL_ORIGIN)
            det_cfg.col_origin = data[POS_W-1:0];
        else if (idx == CFG_DIFF_THR)
            det_cfg.diff_thr = data[THR_W-1:0];
        else if (idx == CFG_HIGH_THR)
            det_cfg.high_thr = data[THR_W-1:0];
        else if (idx == CFG_LOW_THR)
            det_cfg.low_thr = data[THR_W-1:0];
        else if (idx == CFG_SKIP)
            det_cfg.skip_frames = data[SKIP_W-1:0];
    endtask

    // Advance the detector by one accepted pixel; on the frame's last pixel
    // decide the frame and queue the result the core owes.
    task automatic track_pixel(pixel_t px);
        logic [KIND_W-1:0] kind;
        frame_report_t     rep;
        int r;
        int c;
        int addr;
        int d;
        // The frame kind comes from the state before this pixel
        if (reload_pending)
            kind = KIND_LOAD;
        else if (skips_seen == det_cfg.skip_frames)
            kind = KIND_COMPARE;
        else
            kind = KIND_SKIP;
        r = int'(px.row) - int'(det_cfg.row_origin);
        c = int'(px.col) - int'(det_cfg.col_origin);
        if (kind != KIND_SKIP && r >= 0 && c >= 0 && r < WINDOW && c < WINDOW)
        begin
            addr = r * WINDOW + c;
            if (kind == KIND_COMPARE)
            begin
                d = int'(background_luma[addr]) - int'(px.luma);
                if (d < 0)
                    d = -d;
                // Count a change only while below the window area
                if (d * d > int'(det_cfg.diff_thr) && int'(change_tally) < COUNT_CAP)
                    change_tally = change_tally + 1'b1;
            end
            background_luma[addr] = px.luma;
        end
        if (px.last)
        begin
            rep.kind  = kind;
            rep.count = '0;
            rep.done  = 1'b0;
            if (kind == KIND_LOAD)
            begin
                reload_pending = 1'b0;
                skips_seen     = '0;
            end
            else if (kind == KIND_SKIP)
            begin
                // Wraps past 255 when the register was lowered under it
                skips_seen = skips_seen + 1'b1;
            end
            else
            begin
                rep.count = change_tally;
                // Hysteresis: rise above the high mark, fall below the low mark
                if (change_tally > det_cfg.high_thr && !motion_on)
                    motion_on = 1'b1;
                else if (change_tally < det_cfg.low_thr && motion_on)
                begin
                    motion_on      = 1'b0;
                    rep.done       = 1'b1;
                    reload_pending = 1'b1;
                end
                skips_seen = '0;
            end
            change_tally = '0;
            rep.flag     = motion_on;
            expected_frames.push_back(rep);
        end
    endtask

    // ------------------------------------------------------------------
    // Pixel request driver
    // ------------------------------------------------------------------

    // Hold a request until it is taken; after that, or on an empty slot,
    // offer the next pending pixel unless this cycle is a sender gap.
    always @(posedge clk)
    begin : drive_pixels
        pixel_t nxt;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                track_pixel('{luma: luma, row: row, col: col, last: frame_last});
            if (!in_valid || !in_stall)
            begin
                if (pixel_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct)
                begin
                    nxt = pixel_backlog.pop_front();
                    in_valid   <= 1'b1;
                    luma       <= nxt.luma;
                    row        <= nxt.row;
                    col        <= nxt.col;
                    frame_last <= nxt.last;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and output stall
    // ------------------------------------------------------------------

    task automatic flag_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Check every taken result request against the oldest expected frame,
    // then pick the next cycle's stall: a pending long hold-off first.
    always @(posedge clk)
    begin : watch_results
        frame_report_t want;
        frame_report_t got;
        logic          stall_next;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{kind: frame_kind, count: changed_count, flag: moving, done: move_done};
            if (expected_frames.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result kind %0d count %0d moving %0b done %0b",
                                        got.kind, got.count, got.flag, got.done));
            end
            else
            begin
                want = expected_frames.pop_front();
                if (got.kind !== want.kind || got.count !== want.count ||
                    got.flag !== want.flag || got.done !== want.done)
                    flag_mismatch($sformatf({"expected kind %0d count %0d moving %0b done %0b,",
                                             " got kind %0d count %0d moving %0b done %0b"},
                                            want.kind, want.count, want.flag, want.done,
                                            got.kind, got.count, got.flag, got.done));
            end
        end
        if (hold_left > 0)
        begin
            hold_left--;
            stall_next = 1'b1;
        end
        else if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_left     = LONG_HOLD - 1;
            stall_next    = 1'b1;
        end
        else
        begin
            stall_next = ($urandom_range(99) < recv_stall_pct);
        end
        out_stall <= stall_next;
    end

    // Drop the run when nothing has moved on either channel for too long.
    always @(posedge clk)
    begin : progress_watchdog
        if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] watchdog: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("Some tests failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Window-relative coordinates used for every window pixel: both edges
    // and the middle of each axis. All of them get written by the first
    // frame after reset, so a compare never reads a never-written entry.
    function automatic int edge_rel(int k);
        if (k < 6)
            return k;
        else if (k < 12)
            return 111 + k;
        return 222 + k;
    endfunction

    // Still-scene luma at a window position
    function automatic int scene_luma(int r, int c);
        return (r * 5 + c * 3 + 40) % 256;
    endfunction

    function automatic bit in_window(logic [POS_W-1:0] r_abs, logic [POS_W-1:0] c_abs);
        int r;
        int c;
        r = int'(r_abs) - int'(det_cfg.row_origin);
        c = int'(c_abs) - int'(det_cfg.col_origin);
        return (r >= 0 && c >= 0 && r < WINDOW && c < WINDOW);
    endfunction

    // Pixel at a window-relative spot; fall back to the window's first
    // row/column where the spot lies past the frame's last position.
    function automatic pixel_t at_rel(int r, int c, logic [LUMA_W-1:0] value);
        pixel_t px;
        if (int'(det_cfg.row_origin) + r > POS_MAX)
            r = 0;
        if (int'(det_cfg.col_origin) + c > POS_MAX)
            c = 0;
        px.row  = POS_W'(int'(det_cfg.row_origin) + r);
        px.col  = POS_W'(int'(det_cfg.col_origin) + c);
        px.luma = value;
        px.last = 1'b0;
        return px;
    endfunction

    // Window pixel: still scene with a little noise, or a clear change
    function automatic pixel_t window_pixel(int change_pct);
        int r;
        int c;
        int v;
        r = edge_rel($urandom_range(EDGE_POINTS - 1));
        c = edge_rel($urandom_range(EDGE_POINTS - 1));
        if ($urandom_range(99) < change_pct)
        begin
            case ($urandom_range(2))
                0:       v = 0;
                1:       v = 255;
                default: v = scene_luma(r, c) ^ 8'h80;
            endcase
        end
        else
        begin
            v = scene_luma(r, c) + int'($urandom_range(4)) - 2;
            if (v < 0)
                v = 0;
            if (v > 255)
                v = 255;
        end
        return at_rel(r, c, LUMA_W'(v));
    endfunction

    // Pixel anywhere in the frame outside the window
    function automatic pixel_t outside_pixel();
        pixel_t px;
        px.row = POS_W'($urandom);
        px.col = POS_W'($urandom);
        while (in_window(px.row, px.col))
        begin
            px.row = POS_W'($urandom);
            px.col = POS_W'($urandom);
        end
        px.luma = LUMA_W'($urandom);
        px.last = 1'b0;
        return px;
    endfunction

    // Queue one frame of n_pix pixels; mark the final one as frame end.
    task automatic queue_frame(int n_pix, int win_pct, int change_pct);
        pixel_t px;
        for (int i = 0; i < n_pix; i++)
        begin
            if ($urandom_range(99) < win_pct)
                px = window_pixel(change_pct);
            else
                px = outside_pixel();
            px.last = (i == n_pix - 1);
            pixel_backlog.push_back(px);
        end
    endtask

    // Queue a frame hammering the window's first pixel with black/white.
    task automatic queue_flicker_frame(int n_pix);
        pixel_t px;
        for (int i = 0; i < n_pix; i++)
        begin
            px      = at_rel(0, 0, (i % 2) ? 8'hFF : 8'h00);
            px.last = (i == n_pix - 1);
            pixel_backlog.push_back(px);
        end
    endtask

    function automatic int pick_change_pct();
        case ($urandom_range(3))
            0:       return 0;
            1:       return $urandom_range(30, 10);
            2:       return $urandom_range(100, 70);
            default: return $urandom_range(100);
        endcase
    endfunction

    // Wait, from a falling edge, until all requests are out and every
    // result is in, then let the pipe settle.
    task automatic wait_quiet();
        @(negedge clk);
        while (pixel_backlog.size() != 0 || in_valid || expected_frames.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One register write per rising edge; the caller lowers the enable.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        apply_reg(idx, data);
        @(posedge clk);
    endtask

    // Program every register; junk the bits above each register's width.
    task automatic configure(int row_o, int col_o, int diff_thr, int high_thr,
                             int low_thr, int skip_n);
        @(posedge clk);
        write_reg(CFG_ROW_ORIGIN, {5'($urandom), POS_W'(row_o)});
        write_reg(CFG_COL_ORIGIN, {5'($urandom), POS_W'(col_o)});
        write_reg(CFG_DIFF_THR,   THR_W'(diff_thr));
        write_reg(CFG_HIGH_THR,   THR_W'(high_thr));
        write_reg(CFG_LOW_THR,    THR_W'(low_thr));
        write_reg(CFG_SKIP,       {8'($urandom), SKIP_W'(skip_n)});
        write_reg(CFG_NONE,       CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // Random frames under one idling profile, then drain.
    task automatic run_phase(int gap_pct, int stall_pct, int n_frames, int max_pix);
        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        for (int f = 0; f < n_frames; f++)
            queue_frame($urandom_range(max_pix, 1), $urandom_range(100), pick_change_pct());
        wait_quiet();
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset registers: load every window spot used later as the
        // reference, skip three frames, then compare a lightly moving one.
        for (int ri = 0; ri < EDGE_POINTS; ri++)
            for (int ci = 0; ci < EDGE_POINTS; ci++)
                pixel_backlog.push_back(at_rel(edge_rel(ri), edge_rel(ci),
                    LUMA_W'(scene_luma(edge_rel(ri), edge_rel(ci)))));
        pixel_backlog[pixel_backlog.size() - 1].last = 1'b1;
        repeat (3) queue_frame(1, 100, 100);
        queue_frame(12, 75, 25);
        wait_quiet();

        // Any difference counts: every black/white swing on one pixel of a
        // compared frame adds one to the count.
        configure(120, 200, 0, 65535, 0, 0);
        queue_flicker_frame(16);
        wait_quiet();

        // Threshold at a full-scale swing squared: that swing does not exceed it
        configure(120, 200, 65025, 2, 1, 0);
        queue_flicker_frame(4);
        wait_quiet();

        // One below: the same swing counts and starts a motion episode;
        // a still frame ends it, re-arms the load, then compare again.
        configure(120, 200, 65024, 2, 1, 0);
        queue_flicker_frame(4);
        queue_frame(6, 100, 0);
        queue_frame(6, 50, 50);
        queue_frame(6, 50, 50);
        wait_quiet();

        // Random frames, one register setting and idling profile per phase
        configure($urandom_range(POS_MAX), $urandom_range(POS_MAX), 16, 6, 2, 0);
        run_phase(0, 0, 25, 12);

        // Window at the frame origin; flag toggles on nearly every compare
        configure(0, 0, 0, 0, 65535, 1);
        run_phase(82, 0, 25, 12);

        // Window mostly past the frame edge; nothing can count
        configure(POS_MAX, POS_MAX, 65025, 65535, 0, 2);
        run_phase(0, 82, 25, 12);

        configure($urandom_range(POS_MAX), $urandom_range(POS_MAX), 100, 4, 4, 0);
        run_phase(12, 12, 25, 12);

        // Back-pressure: hold results off long enough for the input to stall
        // while short frames keep coming.
        configure(300, 1900, 25, 5, 1, 0);
        long_hold_req = 1'b1;
        run_phase(0, 0, 40, 4);

        // Longest skip interval, then lower it under the running skip count
        // so the count has to wrap around before the next compare.
        configure($urandom_range(POS_MAX), $urandom_range(POS_MAX), 16, 3, 1, 255);
        run_phase(0, 82, 25, 12);
        configure($urandom_range(POS_MAX), $urandom_range(POS_MAX), 16, 3, 1, 1);
        run_phase(12, 12, 260, 1);

        configure($urandom_range(POS_MAX), $urandom_range(POS_MAX), $urandom_range(65025),
                  $urandom_range(15), $urandom_range(15), $urandom_range(3));
        run_phase(0, 0, 25, 12);

        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/fdmd_pkg.sv
hw/rtl/fdmd_front.sv
hw/rtl/fdmd_queue.sv
hw/rtl/fdmd_back.sv
hw/rtl/frame_difference_motion_detector_core.sv
hw/rtl/fdmd_checker.sv
tb/sv/frame_difference_motion_detector_core_test.sv
